// ----- design/wspd_pkg.sv -----
`default_nettype none
package wspd_pkg;

	localparam int TARGET_BITS_DEF = 16;
	localparam int CFG_DATA_W      = 17;
	localparam int CFG_IDX_W       = 3;

	localparam logic [7:0]  BOOST_MAX   = 8'd130;
	localparam logic [14:0] ACCEL_STEP  = 15'd2;
	localparam logic [14:0] DECEL_STEP  = 15'd10;
	localparam logic [14:0] PROSP_LO    = 15'd20480;
	localparam logic [12:0] PROSP_SPAN  = 13'd4096;
	localparam logic [15:0] STEER_LO    = 16'd768;
	localparam logic [12:0] STEER_SPAN  = 13'd4352;
	localparam logic [13:0] SMOOTH_K    = 14'd12288;

	// turn cap rounding: (x + 4352/2) / 4352 as ((x + 2176) >> 8) / 17
	localparam logic [20:0] TURN_RND    = 21'd2176;
	// ceil(2^16 / 17), exact for dividends below 4096
	localparam logic [16:0] RECIP_17    = 17'd3856;

	localparam logic [13:0] DEADBAND_MAX = 14'd14080;
	localparam logic [16:0] GAIN_MAX     = 17'd65536;
	localparam logic [15:0] RATIO_MAX    = 16'd52429;
	localparam logic [16:0] SCALE_MAX    = 17'd65536;
	localparam logic [14:0] TGT_MAX      = 15'd32767;

	typedef enum logic [1:0] {
		FUNC_TICK  = 2'd0,
		FUNC_START = 2'd1,
		FUNC_STOP  = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIFF_EN   = 3'd0,
		CFG_DEADBAND  = 3'd1,
		CFG_GAIN      = 3'd2,
		CFG_RATIO     = 3'd3,
		CFG_SCALE     = 3'd4,
		CFG_RUN_MAX   = 3'd5,
		CFG_WHEEL_MAX = 3'd6,
		CFG_UNUSED    = 3'd7
	} cfg_idx_t;

endpackage
`default_nettype wire

// ----- design/wheel_speed_planner_differential.sv -----
// Wheel speed planner with steering differential.
//
// Input channel (in_valid / in_stall) carries one control tick item: func,
// base_speed, prospect and steer_demand. Output channel (out_valid /
// out_stall) returns exactly one result item per input item.
// The configuration port (cfg_we, cfg_index, cfg_data) writes one register
// per cycle; values above a register's limit saturate, unused indexes drop.
//
// Start, stop and unused codes, and a tick with zero base speed, go from accept
// straight to S_FINISH, which raises out_valid. An update tick runs the shared
// 33x17 multiplier for five steps (smoothstep, turn cap, reciprocal for the
// divide by 17). With the wheel split it adds the restoring divider for the
// ratio, one quotient bit per cycle over 17 bits, and three more multiplies.
// One item is in work at a time and in_stall is high meanwhile; the result
// sits in an output register, so the next item is accepted while an earlier
// result still waits to be taken.
//
// Reset clears the plan (not valid, speed 0) and loads the default register
// values. When the receiver stalls, the finished item waits in the sequencer
// until the output register frees up; in_stall stays high until then.
`default_nettype none
module wheel_speed_planner_differential #(
	parameter int TARGET_BITS = wspd_pkg::TARGET_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output      logic                              in_stall,
	input  wire logic [1:0]                        func,
	input  wire logic signed [15:0]                base_speed,
	input  wire logic [15:0]                       prospect,
	input  wire logic signed [15:0]                steer_demand,
	output      logic                              out_valid,
	input  wire logic                              out_stall,
	output      logic [14:0]                       left_speed,
	output      logic [14:0]                       right_speed,
	output      logic [14:0]                       planned_target,
	output      logic [14:0]                       boosted_target,
	output      logic [14:0]                       turn_limit,
	output      logic                              diff_active,
	input  wire logic                              cfg_we,
	input  wire logic [wspd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [wspd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import wspd_pkg::*;

	// Clamp imposed by the target width
	localparam int TMAX_I = (TARGET_BITS >= 16) ? 32767 : ((1 << (TARGET_BITS - 1)) - 1);
	localparam logic [14:0] TMAX = 15'(TMAX_I);

	typedef enum logic [3:0] {
		S_IDLE, S_NN, S_ND, S_NS, S_TURN, S_RCP, S_PLAN, S_GE, S_DIV, S_RED, S_OUT,
		S_FINISH
	} state_t;

	state_t state_q;

	// configuration registers
	logic        diff_en_q;
	logic [13:0] deadband_q;
	logic [16:0] gain_q;
	logic [15:0] ratio_lim_q;
	logic [16:0] scale_q;
	logic [14:0] run_max_q;
	logic [14:0] wheel_max_q;

	// plan state
	logic [14:0] plan_q;
	logic        plan_valid_q;

	// item working registers
	logic [14:0] b_q;
	logic [7:0]  d_q;
	logic [12:0] n_q;
	logic [12:0] k_q;
	logic [15:0] e_q;
	logic        left_turn_q;
	logic [32:0] t_q;
	logic [11:0] y_q;
	logic [14:0] vis_q;
	logic [14:0] turn_q;
	logic [14:0] bs_q;
	logic [15:0] r_q;
	logic [31:0] red_q;

	// divider
	logic [31:0] rem_q;
	logic [16:0] lo_q;
	logic [31:0] den_q;
	logic [15:0] quo_q;
	logic [4:0]  cnt_q;

	// pending result
	logic [14:0] res_left_q, res_right_q, res_plan_q, res_vis_q, res_turn_q;
	logic        res_act_q;

	// output register
	logic        out_valid_q;
	logic [14:0] left_q, right_q, planned_q, vision_q, turn_lim_q;
	logic        act_q;

	// derived clamps
	logic [14:0] run_max, wheel_max;
	assign run_max   = (run_max_q   > TMAX) ? TMAX : run_max_q;
	assign wheel_max = (wheel_max_q > TMAX) ? TMAX : wheel_max_q;

	// input decode at accept
	logic        in_acc;
	func_t       fn_in;
	logic [14:0] b_in;
	logic [15:0] mag_in;
	logic [15:0] e_in;
	logic [12:0] n_in;
	logic [12:0] k_in;
	logic [15:0] pmax_in;
	logic [14:0] pmax15;
	logic [15:0] p_off;
	logic [15:0] s_off;

	assign in_acc = in_valid && !in_stall;
	assign fn_in  = func_t'(func);

	always_comb begin
		if (base_speed[15])
			b_in = '0;
		else if (base_speed[14:0] > run_max)
			b_in = run_max;
		else
			b_in = base_speed[14:0];
		mag_in = steer_demand[15] ? 16'(-steer_demand) : 16'(steer_demand);
		e_in   = (mag_in > {2'b00, deadband_q}) ? (mag_in - {2'b00, deadband_q}) : '0;
		p_off  = prospect - {1'b0, PROSP_LO};
		if (prospect <= {1'b0, PROSP_LO})
			n_in = '0;
		else if (p_off > {3'b000, PROSP_SPAN})
			n_in = PROSP_SPAN;
		else
			n_in = p_off[12:0];
		s_off = mag_in - STEER_LO;
		if (mag_in <= STEER_LO)
			k_in = '0;
		else if (s_off > {3'b000, STEER_SPAN})
			k_in = STEER_SPAN;
		else
			k_in = s_off[12:0];
		pmax_in = {1'b0, b_in} + {8'd0, BOOST_MAX};
		pmax15  = (pmax_in > {1'b0, run_max}) ? run_max : pmax_in[14:0];
	end

	// shared multiplier
	logic [32:0] mul_a;
	logic [16:0] mul_b;
	logic [49:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_NN: begin
				mul_a = {20'd0, n_q};
				mul_b = {4'd0, n_q};
			end
			S_ND: begin
				mul_a = t_q;
				mul_b = {9'd0, d_q};
			end
			S_NS: begin
				mul_a = t_q;
				mul_b = {3'd0, SMOOTH_K - {n_q, 1'b0}};
			end
			S_TURN: begin
				mul_a = {25'd0, d_q};
				mul_b = {4'd0, STEER_SPAN - k_q};
			end
			S_RCP: begin
				mul_a = {21'd0, y_q};
				mul_b = RECIP_17;
			end
			S_GE: begin
				mul_a = {17'd0, e_q};
				mul_b = gain_q;
			end
			S_RED: begin
				mul_a = {18'd0, bs_q};
				mul_b = {1'b0, r_q};
			end
			S_OUT: begin
				mul_a = {1'b0, red_q};
				mul_b = scale_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 50'(mul_a) * 50'(mul_b);
	end

	// divider step
	logic [32:0] div_sh, div_diff;
	logic        div_bit;
	logic [16:0] div_quo;
	assign div_sh   = {rem_q, lo_q[16]};
	assign div_diff = div_sh - {1'b0, den_q};
	assign div_bit  = (div_sh >= {1'b0, den_q});
	assign div_quo  = {quo_q, div_bit};

	// step-local arithmetic
	logic [49:0] vis_sum;
	logic [20:0] turn_rnd;
	logic [31:0] ge;
	logic [31:0] ratio_den;
	logic [47:0] ratio_num;
	logic [14:0] raw, plan_base, plan_next, slew_diff, bs_next;
	logic        split_on;
	logic [32:0] inner_sum;
	logic [49:0] outer_sum;
	logic [15:0] inner_w;
	logic [17:0] outer_w;
	logic [14:0] inner_c, outer_c, bs_c;

	always_comb begin
		vis_sum   = mul_p + (50'd1 << 35);
		turn_rnd  = mul_p[20:0] + TURN_RND;
		ge        = mul_p[31:0];
		ratio_den = 32'd33554432 + ge;
		ratio_num = {ge, 16'd0} + {17'd0, ratio_den[31:1]};

		raw       = (vis_q < turn_q) ? vis_q : turn_q;
		plan_base = plan_valid_q ? plan_q : b_q;
		if (raw > plan_base) begin
			slew_diff = raw - plan_base;
			plan_next = plan_base + ((slew_diff > ACCEL_STEP) ? ACCEL_STEP : slew_diff);
		end else begin
			slew_diff = plan_base - raw;
			plan_next = plan_base - ((slew_diff > DECEL_STEP) ? DECEL_STEP : slew_diff);
		end
		bs_next  = (plan_next > run_max) ? run_max : plan_next;
		bs_c     = (bs_next > wheel_max) ? wheel_max : bs_next;
		split_on = diff_en_q && (bs_next != '0) && (e_q != '0) && (gain_q != '0)
			&& (ratio_lim_q != '0);

		inner_sum = {2'd0, bs_q, 16'd0} - {1'b0, red_q} + 33'd32768;
		outer_sum = {3'd0, bs_q, 32'd0} + mul_p + (50'd1 << 31);
		inner_w   = inner_sum[31:16];
		outer_w   = outer_sum[49:32];
		inner_c   = (inner_w > {1'b0, wheel_max}) ? wheel_max : inner_w[14:0];
		outer_c   = (outer_w > {3'd0, wheel_max}) ? wheel_max : outer_w[14:0];
	end

	assign in_stall = (state_q != S_IDLE);

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_en_q   <= 1'b1;
			deadband_q  <= 14'd768;
			gain_q      <= 17'd15729;
			ratio_lim_q <= 16'd52429;
			scale_q     <= 17'd13107;
			run_max_q   <= 15'd1000;
			wheel_max_q <= 15'd2000;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DIFF_EN:   diff_en_q <= cfg_data[0];
				CFG_DEADBAND:  deadband_q <= (cfg_data > {3'd0, DEADBAND_MAX}) ?
					DEADBAND_MAX : cfg_data[13:0];
				CFG_GAIN:      gain_q <= (cfg_data > GAIN_MAX) ? GAIN_MAX : cfg_data;
				CFG_RATIO:     ratio_lim_q <= (cfg_data > {1'b0, RATIO_MAX}) ?
					RATIO_MAX : cfg_data[15:0];
				CFG_SCALE:     scale_q <= (cfg_data > SCALE_MAX) ? SCALE_MAX : cfg_data;
				CFG_RUN_MAX:   run_max_q <= (cfg_data > {2'd0, TGT_MAX}) ?
					TGT_MAX : cfg_data[14:0];
				CFG_WHEEL_MAX: wheel_max_q <= (cfg_data > {2'd0, TGT_MAX}) ?
					TGT_MAX : cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			plan_q       <= '0;
			plan_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			cnt_q        <= '0;
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && !out_stall && (state_q != S_FINISH))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						b_q         <= b_in;
						d_q         <= 8'(pmax15 - b_in);
						n_q         <= n_in;
						k_q         <= k_in;
						e_q         <= e_in;
						left_turn_q <= !steer_demand[15] && (steer_demand != '0);
						res_left_q  <= '0;
						res_right_q <= '0;
						res_act_q   <= 1'b0;
						res_plan_q  <= (fn_in == FUNC_START) ? b_in :
							((fn_in == FUNC_NOP) ? plan_q : '0);
						res_vis_q   <= (fn_in == FUNC_START) ? b_in : '0;
						res_turn_q  <= (fn_in == FUNC_START) ? b_in : '0;
						state_q     <= (fn_in == FUNC_TICK && b_in != '0) ? S_NN : S_FINISH;
						case (fn_in)
							FUNC_START: begin
								plan_q       <= b_in;
								plan_valid_q <= 1'b1;
							end
							FUNC_STOP: begin
								plan_q       <= '0;
								plan_valid_q <= 1'b0;
							end
							FUNC_TICK: begin
								if (b_in == '0) begin
									plan_q       <= '0;
									plan_valid_q <= 1'b1;
								end
							end
							default: ;
						endcase
					end
				end
				S_NN: begin
					t_q     <= mul_p[32:0];
					state_q <= S_ND;
				end
				S_ND: begin
					t_q     <= mul_p[32:0];
					state_q <= S_NS;
				end
				S_NS: begin
					vis_q   <= b_q + 15'(vis_sum[49:36]);
					state_q <= S_TURN;
				end
				S_TURN: begin
					// round and take out the factor 256 of 4352
					y_q     <= turn_rnd[19:8];
					state_q <= S_RCP;
				end
				S_RCP: begin
					turn_q  <= b_q + mul_p[30:16];
					state_q <= S_PLAN;
				end
				S_PLAN: begin
					plan_q       <= plan_next;
					plan_valid_q <= 1'b1;
					bs_q         <= bs_next;
					res_plan_q   <= plan_next;
					res_vis_q    <= vis_q;
					res_turn_q   <= turn_q;
					res_left_q   <= bs_c;
					res_right_q  <= bs_c;
					state_q      <= split_on ? S_GE : S_FINISH;
				end
				S_GE: begin
					rem_q   <= {1'b0, ratio_num[47:17]};
					lo_q    <= ratio_num[16:0];
					den_q   <= ratio_den;
					quo_q   <= '0;
					cnt_q   <= 5'd16;
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= div_bit ? div_diff[31:0] : div_sh[31:0];
					lo_q  <= {lo_q[15:0], 1'b0};
					quo_q <= div_quo[15:0];
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == '0) begin
						r_q     <= (div_quo > {1'b0, ratio_lim_q}) ? ratio_lim_q : div_quo[15:0];
						state_q <= S_RED;
					end
				end
				S_RED: begin
					red_q   <= mul_p[31:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					res_left_q  <= left_turn_q ? inner_c : outer_c;
					res_right_q <= left_turn_q ? outer_c : inner_c;
					res_act_q   <= 1'b1;
					state_q     <= S_FINISH;
				end
				S_FINISH: begin
					// hold until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						left_q      <= res_left_q;
						right_q     <= res_right_q;
						planned_q   <= res_plan_q;
						vision_q    <= res_vis_q;
						turn_lim_q  <= res_turn_q;
						act_q       <= res_act_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign left_speed     = left_q;
	assign right_speed    = right_q;
	assign planned_target = planned_q;
	assign boosted_target = vision_q;
	assign turn_limit     = turn_lim_q;
	assign diff_active    = act_q;

	// boosted target stays within the boost window above the base
	a_vis_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAN) |-> (vis_q >= b_q) && ({1'b0, vis_q} <= {1'b0, b_q} + 16'd130))
		else $error("boosted target outside boost window");

	// turn cap never falls below the base
	a_turn_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLAN) |-> (turn_q >= b_q))
		else $error("turn cap below base");

	// capped ratio respects the limit
	a_ratio_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |-> (r_q <= ratio_lim_q))
		else $error("ratio above limit");

	// the plan moves by at most one slew step per tick
	a_slew: assert property (@(posedge clk) disable iff (!arst_n)
		($past(state_q) == S_PLAN && $past(plan_valid_q)) |->
		(({1'b0, plan_q} <= {1'b0, $past(plan_q)} + 16'd2)
		&& ({1'b0, plan_q} + 16'd10 >= {1'b0, $past(plan_q)})))
		else $error("plan slew exceeded");

endmodule
`default_nettype wire
